// ===== rtl/iou_match_classifier_assert.svh =====
// ----------------------------------------------------------------------------
// iou match classifier assertion macros
// concurrent check wrappers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef IOU_MATCH_CLASSIFIER_ASSERT_SVH
`define IOU_MATCH_CLASSIFIER_ASSERT_SVH

`ifndef SYNTH

`define IMC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define IMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define IMC_ASSERT_NOW(label, clk, rst, ante, cons, msg)

`define IMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/imc_pkg.sv =====
// ----------------------------------------------------------------------------
// imc_pkg
// shared widths, register codes and helpers for the iou match classifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package imc_pkg;

  localparam int COORD_W  = 12;
  localparam int EDGE_W   = COORD_W + 1;
  localparam int BOX_W    = 4 * COORD_W;
  localparam int AREA_W   = 2 * COORD_W;
  localparam int UNI_W    = AREA_W + 1;
  localparam int RATIO_W  = 16;
  localparam int QUO_W    = RATIO_W + 1;
  localparam int CNT_W    = 8;
  localparam int TIU_W    = 2;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 64;
  localparam int MAX_TRUTHS = 2;

  localparam logic [BOX_W-1:0] TRUTH_RESET [MAX_TRUTHS] = '{
    48'd7285557264856,
    48'd7423264531164
  };
  localparam logic [TIU_W-1:0]   TIU_RESET    = 2'd2;
  localparam logic [RATIO_W-1:0] THRESH_RESET = 16'd26214;

  typedef enum logic [1:0] {
    REG_TRUTH_A       = 2'd0,
    REG_TRUTH_B       = 2'd1,
    REG_TRUTHS_IN_USE = 2'd2,
    REG_THRESHOLD     = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    FLD_X = 2'd0,
    FLD_Y = 2'd1,
    FLD_W = 2'd2,
    FLD_H = 2'd3
  } box_fld_t;

  typedef struct packed {
    logic [TIU_W-1:0]   truths_in_use;
    logic [RATIO_W-1:0] threshold;
  } cfg_ctl_t;

  function automatic logic [COORD_W-1:0] box_field(input logic [BOX_W-1:0] box,
                                                   input box_fld_t fld);
    return box[fld*COORD_W +: COORD_W];
  endfunction

endpackage

// ===== rtl/imc_if.sv =====
// ----------------------------------------------------------------------------
// imc_if
// valid/ready channels for detection beats and result beats
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface imc_det_if;
  logic                        valid;
  logic                        ready;
  logic [imc_pkg::COORD_W-1:0] det_x;
  logic [imc_pkg::COORD_W-1:0] det_y;
  logic [imc_pkg::COORD_W-1:0] det_w;
  logic [imc_pkg::COORD_W-1:0] det_h;
  logic                        last_in_frame;

  modport source (output valid, det_x, det_y, det_w, det_h, last_in_frame, input ready);
  modport sink   (input valid, det_x, det_y, det_w, det_h, last_in_frame, output ready);
endinterface

interface imc_res_if;
  logic                        valid;
  logic                        ready;
  logic [imc_pkg::RATIO_W-1:0] best_ratio;
  logic                        is_match;
  logic [imc_pkg::CNT_W-1:0]   match_count;
  logic [imc_pkg::CNT_W-1:0]   miss_count;
  logic                        frame_done;

  modport source (output valid, best_ratio, is_match, match_count, miss_count, frame_done,
                  input ready);
  modport sink   (input valid, best_ratio, is_match, match_count, miss_count, frame_done,
                  output ready);
endinterface

// ===== rtl/imc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// imc_cfg_regs
// apb register file: truth boxes, truths in use and match threshold
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imc_cfg_regs #(
  parameter int NUM_TRUTHS = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [imc_pkg::PADDR_W-1:0]  paddr,
  input  logic [imc_pkg::PDATA_W-1:0]  pwdata,
  output logic [imc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [imc_pkg::BOX_W-1:0]    truth [NUM_TRUTHS],
  output imc_pkg::cfg_ctl_t            cfg_ctl
);
  import imc_pkg::*;

  reg_idx_t         idx;
  logic             wr;
  logic [BOX_W-1:0] truth_b_rd;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:3]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  for (genvar g = 0; g < NUM_TRUTHS; g++) begin : g_truth
    localparam reg_idx_t CODE = (g == 0) ? REG_TRUTH_A : REG_TRUTH_B;
    always_ff @(posedge clk) begin
      if (rst) begin
        truth[g] <= TRUTH_RESET[g];
      end else if (wr && idx == CODE) begin
        truth[g] <= pwdata[BOX_W-1:0];
      end
    end
  end

  if (NUM_TRUTHS > 1) begin : g_rd_b
    assign truth_b_rd = truth[1];
  end else begin : g_no_b
    assign truth_b_rd = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_ctl.truths_in_use <= TIU_RESET;
      cfg_ctl.threshold     <= THRESH_RESET;
    end else if (wr) begin
      if (idx == REG_TRUTHS_IN_USE) begin
        cfg_ctl.truths_in_use <= pwdata[TIU_W-1:0];
      end
      if (idx == REG_THRESHOLD) begin
        cfg_ctl.threshold <= pwdata[RATIO_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_TRUTH_A:       prdata = PDATA_W'(truth[0]);
      REG_TRUTH_B:       prdata = PDATA_W'(truth_b_rd);
      REG_TRUTHS_IN_USE: prdata = PDATA_W'(cfg_ctl.truths_in_use);
      REG_THRESHOLD:     prdata = PDATA_W'(cfg_ctl.threshold);
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== rtl/imc_div.sv =====
// ----------------------------------------------------------------------------
// imc_div
// serial restoring divider: intersection over union as saturated q0.16
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "iou_match_classifier_assert.svh"

module imc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [imc_pkg::AREA_W-1:0]  dividend,
  input  logic [imc_pkg::UNI_W-1:0]   divisor,
  output logic                        busy,
  output logic                        done,
  output logic [imc_pkg::RATIO_W-1:0] ratio
);
  import imc_pkg::*;

  localparam int STEP_W = $clog2(QUO_W);

  logic [UNI_W-1:0]  divisor_q;
  logic [UNI_W-1:0]  rem;
  logic [QUO_W-1:0]  quo;
  logic [STEP_W-1:0] step;
  logic              first;
  logic [UNI_W:0]    trial;
  logic [UNI_W:0]    diff;
  logic              ge;

  assign trial = first ? {1'b0, rem} : {rem, 1'b0};
  assign ge    = trial >= {1'b0, divisor_q};
  assign diff  = trial - {1'b0, divisor_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      divisor_q <= divisor;
      rem       <= UNI_W'(dividend);
      quo       <= '0;
      step      <= STEP_W'(QUO_W - 1);
      first     <= 1'b1;
    end else if (busy) begin
      rem   <= ge ? diff[UNI_W-1:0] : trial[UNI_W-1:0];
      quo   <= {quo[QUO_W-2:0], ge};
      step  <= step - 1'b1;
      first <= 1'b0;
    end
  end

  // zero union gives zero; a full quotient bit means 1.0
  assign ratio = (divisor_q == '0) ? '0 :
                 quo[QUO_W-1]      ? '1 : quo[RATIO_W-1:0];

  `IMC_ASSERT_NEXT(a_div_start_busy, clk, rst, start, busy, "divider not busy after start")
  `IMC_ASSERT_NOW(a_div_rem_bound, clk, rst, busy && !first, rem < divisor_q || divisor_q == '0, "remainder not below divisor")

endmodule

// ===== rtl/iou_match_classifier.sv =====
// ----------------------------------------------------------------------------
// iou_match_classifier
// scores each detection against the truth boxes by intersection over union
// ----------------------------------------------------------------------------
// a detection beat on det carries one box and a last-in-frame mark. det.ready
// is high only while no detection is in work; one is taken at a time.
// for each truth in use a small sequencer runs geometry, three products
// through one shared 12x12 multiplier, the union subtract and a 17-step
// serial divider, then keeps the best. the result beat becomes valid in
// the same cycle that det.ready returns.
// each detection gives one result beat on res: best ratio, match flag, the
// running match and miss counts of the frame and a frame-done echo.
// the result sits in an output register; the next detection is taken while
// it waits, and the sequencer holds in its final step if res is stalled.
// reset restores the truth boxes, truths in use and threshold to defaults and
// clears both counts; counts also clear after a frame-done result.
// apb registers sit at 8-byte steps: truth a, truth b, truths in use, threshold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "iou_match_classifier_assert.svh"

module iou_match_classifier #(
  parameter int NUM_TRUTHS = 2
) (
  input  logic                        clk,
  input  logic                        rst,
  imc_det_if.sink                     det,
  imc_res_if.source                   res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [imc_pkg::PADDR_W-1:0] paddr,
  input  logic [imc_pkg::PDATA_W-1:0] pwdata,
  output logic [imc_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import imc_pkg::*;

  localparam int TIDX_W = (NUM_TRUTHS > 1) ? $clog2(NUM_TRUTHS) : 1;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_GEOM  = 10'b00_0000_0010,
    S_MUL_I = 10'b00_0000_0100,
    S_MUL_D = 10'b00_0000_1000,
    S_MUL_T = 10'b00_0001_0000,
    S_UNION = 10'b00_0010_0000,
    S_DIV   = 10'b00_0100_0000,
    S_WAIT  = 10'b00_1000_0000,
    S_BEST  = 10'b01_0000_0000,
    S_FIN   = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  logic [BOX_W-1:0]   truth [NUM_TRUTHS];
  cfg_ctl_t           cfg_ctl;

  logic [COORD_W-1:0] dx, dy, dw, dh;
  logic               last_q;
  logic [TIDX_W-1:0]  tidx;
  logic [TIDX_W-1:0]  last_idx;
  logic [COORD_W-1:0] ow, oh;
  logic [AREA_W-1:0]  inter;
  logic [UNI_W-1:0]   acc;
  logic [UNI_W-1:0]   uni;
  logic [RATIO_W-1:0] best;
  logic [CNT_W-1:0]   hit_tally;
  logic [CNT_W-1:0]   miss_tally;

  logic [BOX_W-1:0]   tbox;
  logic [COORD_W-1:0] tx, ty, tw, th;
  logic [EDGE_W-1:0]  left, top, right, bottom;
  logic [EDGE_W-1:0]  ow_diff, oh_diff;
  logic [COORD_W-1:0] mul_a, mul_b;
  logic [AREA_W-1:0]  prod;
  logic [TIU_W-1:0]   tiu_eff;
  logic               accept;
  logic               out_free;
  logic               fin_load;
  logic               hit;
  logic [CNT_W-1:0]   hit_tally_next;
  logic [CNT_W-1:0]   miss_tally_next;

  logic               div_start;
  logic               div_busy;
  logic               div_done;
  logic [RATIO_W-1:0] div_ratio;

  imc_cfg_regs #(
    .NUM_TRUTHS (NUM_TRUTHS)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .truth   (truth),
    .cfg_ctl (cfg_ctl)
  );

  imc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (inter),
    .divisor  (uni),
    .busy     (div_busy),
    .done     (div_done),
    .ratio    (div_ratio)
  );

  assign det.ready = (state == S_IDLE) && !rst;
  assign accept    = det.valid & det.ready;
  assign out_free  = !res.valid || res.ready;
  assign fin_load  = (state == S_FIN) && out_free;
  assign div_start = (state == S_DIV);

  // clamp truths in use to 1..NUM_TRUTHS
  always_comb begin
    if (cfg_ctl.truths_in_use == '0) begin
      tiu_eff = TIU_W'(1);
    end else if (cfg_ctl.truths_in_use > TIU_W'(NUM_TRUTHS)) begin
      tiu_eff = TIU_W'(NUM_TRUTHS);
    end else begin
      tiu_eff = cfg_ctl.truths_in_use;
    end
  end

  // overlap geometry of the current truth
  assign tbox   = truth[tidx];
  assign tx     = box_field(tbox, FLD_X);
  assign ty     = box_field(tbox, FLD_Y);
  assign tw     = box_field(tbox, FLD_W);
  assign th     = box_field(tbox, FLD_H);
  assign left   = (dx > tx) ? EDGE_W'(dx) : EDGE_W'(tx);
  assign top    = (dy > ty) ? EDGE_W'(dy) : EDGE_W'(ty);
  assign right  = ((EDGE_W'(dx) + EDGE_W'(dw)) < (EDGE_W'(tx) + EDGE_W'(tw))) ?
                  (EDGE_W'(dx) + EDGE_W'(dw)) : (EDGE_W'(tx) + EDGE_W'(tw));
  assign bottom = ((EDGE_W'(dy) + EDGE_W'(dh)) < (EDGE_W'(ty) + EDGE_W'(th))) ?
                  (EDGE_W'(dy) + EDGE_W'(dh)) : (EDGE_W'(ty) + EDGE_W'(th));
  assign ow_diff = right - left;
  assign oh_diff = bottom - top;

  // shared multiplier
  always_comb begin
    mul_a = ow;
    mul_b = oh;
    unique case (state)
      S_MUL_D: begin
        mul_a = dw;
        mul_b = dh;
      end
      S_MUL_T: begin
        mul_a = tw;
        mul_b = th;
      end
      default: begin
        mul_a = ow;
        mul_b = oh;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  assign hit             = best > cfg_ctl.threshold;
  assign hit_tally_next  = (hit && hit_tally != '1) ? hit_tally + 1'b1 : hit_tally;
  assign miss_tally_next = (!hit && miss_tally != '1) ? miss_tally + 1'b1 : miss_tally;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_GEOM;
      S_GEOM:  state_next = S_MUL_I;
      S_MUL_I: state_next = S_MUL_D;
      S_MUL_D: state_next = S_MUL_T;
      S_MUL_T: state_next = S_UNION;
      S_UNION: state_next = S_DIV;
      S_DIV:   state_next = S_WAIT;
      S_WAIT:  if (div_done) state_next = S_BEST;
      S_BEST:  state_next = (tidx == last_idx) ? S_FIN : S_GEOM;
      S_FIN:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      hit_tally  <= '0;
      miss_tally <= '0;
      res.valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (fin_load) begin
        res.valid  <= 1'b1;
        hit_tally  <= last_q ? '0 : hit_tally_next;
        miss_tally <= last_q ? '0 : miss_tally_next;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dx       <= det.det_x;
      dy       <= det.det_y;
      dw       <= det.det_w;
      dh       <= det.det_h;
      last_q   <= det.last_in_frame;
      tidx     <= '0;
      last_idx <= TIDX_W'(tiu_eff - 1'b1);
      best     <= '0;
    end
    unique case (state)
      S_GEOM: begin
        ow <= (right > left) ? ow_diff[COORD_W-1:0] : '0;
        oh <= (bottom > top) ? oh_diff[COORD_W-1:0] : '0;
      end
      S_MUL_I: inter <= prod;
      S_MUL_D: acc   <= UNI_W'(prod);
      S_MUL_T: acc   <= acc + UNI_W'(prod);
      S_UNION: uni   <= acc - UNI_W'(inter);
      S_BEST: begin
        if (div_ratio > best) begin
          best <= div_ratio;
        end
        if (tidx != last_idx) begin
          tidx <= tidx + 1'b1;
        end
      end
      default: ;
    endcase
    if (fin_load) begin
      res.best_ratio  <= best;
      res.is_match    <= hit;
      res.match_count <= hit_tally_next;
      res.miss_count  <= miss_tally_next;
      res.frame_done  <= last_q;
    end
  end

  `IMC_ASSERT_NEXT(a_accept_starts, clk, rst, accept, state == S_GEOM, "accepted beat did not start work")
  `IMC_ASSERT_NOW(a_match_flag, clk, rst, res.valid, res.is_match == (res.best_ratio > cfg_ctl.threshold), "match flag disagrees with threshold")
  `IMC_ASSERT_NEXT(a_frame_clear, clk, rst, fin_load && last_q, hit_tally == '0 && miss_tally == '0, "counts not cleared after frame")
  `IMC_ASSERT_NOW(a_wait_busy, clk, rst, state == S_WAIT && !div_done, div_busy, "divider idle while waiting")

endmodule
